/* hw/rtl/frl_pkg.sv */
package frl_pkg;

    // sample and accumulator geometry
    localparam int SAMPLE_BITS = 16;
    localparam int MAX_FRAME   = 1024;
    localparam int SMP_W       = 16;
    localparam int RMS_W       = 16;
    localparam int LEN_W       = 11;
    localparam int SUM_W       = 40;
    localparam int CNT_W       = $clog2(MAX_FRAME + 1);
    localparam int SQ_W        = 2 * SAMPLE_BITS;
    localparam int ACC_W       = ((SQ_W > SUM_W) ? SQ_W : SUM_W) + 1;

    // back end iteration widths
    localparam int ROOT_W      = SUM_W / 2;
    localparam int STEP_W      = $clog2(SUM_W);

    // frame queue, depth a power of two
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QLVL_W      = $clog2(QDEPTH + 1);

    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    // totals of one finished frame
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] count;
        logic             overflow;
    } frl_frame_t;

    // front to queue
    typedef struct packed {
        logic       valid;
        frl_frame_t frame;
    } frl_push_t;

endpackage

/* hw/rtl/frame_rms_level.sv */
// channel  | direction | ports                                      | carries
// s_       | in        | s_valid s_ready s_sample s_last_sample     | one sample word
// m_       | out       | m_valid m_ready m_rms_value                | one frame result word
//          |           | m_frame_length m_length_overflow           |
//
// the front end takes one sample word per cycle while s_ready is high: square, then saturating accumulate
// each frame result is worked out in the back end by the restoring divider
//   (one quotient bit a cycle) and then the root (one bit a cycle)
// finished frames wait in a queue of QDEPTH entries; s_ready drops when it is full
//   or its last free entry is claimed by a frame still in the accumulate stage
// aresetn is synchronous, active low; it clears counters, sums, queue and state
// a result held on m_ is not blocking: the back end works on the next frame meanwhile
module frame_rms_level import frl_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [SMP_W-1:0] s_sample,
    input  logic                    s_last_sample,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [RMS_W-1:0]        m_rms_value,
    output logic [LEN_W-1:0]        m_frame_length,
    output logic                    m_length_overflow
);

    // front to queue
    frl_push_t  push;
    logic       reserve;
    logic       can_take;

    // queue to back end
    logic       pop_valid;
    logic       pop_ready;
    frl_frame_t pop_frame;

    // sample accumulation, frame boundary detection
    frl_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_sample      (s_sample),
        .s_last_sample (s_last_sample),
        .q_can_take    (can_take),
        .q_reserve     (reserve),
        .q_push        (push)
    );

    // decouples the per-sample path from the slow per-frame math
    frl_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .reserve   (reserve),
        .can_take  (can_take),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_frame (pop_frame)
    );

    // mean by iterative division, then integer square root
    frl_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .q_valid           (pop_valid),
        .q_ready           (pop_ready),
        .q_frame           (pop_frame),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_rms_value       (m_rms_value),
        .m_frame_length    (m_frame_length),
        .m_length_overflow (m_length_overflow)
    );

endmodule

/* hw/rtl/frl_front.sv */
module frl_front import frl_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic signed [SMP_W-1:0] s_sample,
    input  logic                   s_last_sample,
    input  logic                   q_can_take,
    output logic                   q_reserve,
    output frl_push_t              q_push
);

    logic [SAMPLE_BITS-1:0] raw;
    logic [SAMPLE_BITS-1:0] mag;
    logic [SQ_W-1:0]        sq;
    logic                   accept;
    logic                   keep;

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              ovf_reg, ovf_next;
    logic              a_valid_reg;
    logic              a_last_reg;
    logic              a_keep_reg;
    logic [SQ_W-1:0]   a_sq_reg;
    logic [CNT_W-1:0]  a_count_reg;
    logic              a_ovf_reg;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [ACC_W-1:0]  acc;
    logic [SUM_W-1:0]  sum_add;

    assign s_ready   = q_can_take;
    assign accept    = s_valid && s_ready;
    assign q_reserve = a_valid_reg && a_last_reg;

    // bits above the sample width are ignored, top kept bit is the sign
    assign raw  = SAMPLE_BITS'($unsigned(s_sample));
    assign mag  = raw[SAMPLE_BITS-1] ? (~raw + 1'b1) : raw;
    assign sq   = SQ_W'(mag) * SQ_W'(mag);
    assign keep = cnt_reg < CNT_W'(MAX_FRAME);

    always_comb begin
        cnt_next = cnt_reg;
        ovf_next = ovf_reg;
        if (accept) begin
            if (s_last_sample) begin
                cnt_next = '0;
                ovf_next = 1'b0;
            end else if (keep) begin
                cnt_next = cnt_reg + 1'b1;
            end else begin
                ovf_next = 1'b1;
            end
        end
    end

    // saturating accumulate
    assign acc     = ACC_W'(sum_reg) + ACC_W'(a_sq_reg);
    assign sum_add = !a_keep_reg ? sum_reg :
                     (acc > ACC_W'(SUM_MAX)) ? SUM_MAX : acc[SUM_W-1:0];

    always_comb begin
        sum_next           = sum_reg;
        q_push.valid       = 1'b0;
        q_push.frame.sum      = sum_add;
        q_push.frame.count    = a_count_reg;
        q_push.frame.overflow = a_ovf_reg;
        if (a_valid_reg) begin
            if (a_last_reg) begin
                q_push.valid = 1'b1;
                sum_next     = '0;
            end else begin
                sum_next = sum_add;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            ovf_reg     <= 1'b0;
            a_valid_reg <= 1'b0;
            a_last_reg  <= 1'b0;
            sum_reg     <= '0;
        end else begin
            cnt_reg     <= cnt_next;
            ovf_reg     <= ovf_next;
            a_valid_reg <= accept;
            a_last_reg  <= accept && s_last_sample;
            sum_reg     <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            a_sq_reg    <= sq;
            a_keep_reg  <= keep;
            a_count_reg <= keep ? cnt_reg + 1'b1 : cnt_reg;
            a_ovf_reg   <= ovf_reg || !keep;
        end
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_FRAME))
        else $error("sample count beyond frame limit");

    a_no_accept_full: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_last_sample |=> q_reserve)
        else $error("last sample not tracked for queue room");

endmodule

/* hw/rtl/frl_queue.sv */
module frl_queue import frl_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  frl_push_t  push,
    input  logic       reserve,
    output logic       can_take,
    output logic       pop_valid,
    input  logic       pop_ready,
    output frl_frame_t pop_frame
);

    frl_frame_t         mem_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QLVL_W-1:0]  level_reg, level_next;
    logic               pop;
    logic [QLVL_W:0]    committed;

    assign pop       = pop_valid && pop_ready;
    assign pop_valid = level_reg != '0;
    assign pop_frame = mem_reg[rd_ptr_reg];

    // room for one more frame beyond what is stored or already on its way
    assign committed = (QLVL_W+1)'(level_reg) + (QLVL_W+1)'(reserve);
    assign can_take  = committed < (QLVL_W+1)'(QDEPTH);

    always_comb begin
        level_next = level_reg;
        case ({push.valid, pop})
            2'b10:   level_next = level_reg + 1'b1;
            2'b01:   level_next = level_reg - 1'b1;
            default: level_next = level_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            level_reg <= level_next;
            if (push.valid) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push.valid) begin
            mem_reg[wr_ptr_reg] <= push.frame;
        end
    end

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push.valid && !pop && level_reg == QLVL_W'(QDEPTH)))
        else $error("frame queue overrun");

    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        level_reg <= QLVL_W'(QDEPTH))
        else $error("frame queue level out of range");

endmodule

/* hw/rtl/frl_back.sv */
module frl_back import frl_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_valid,
    output logic             q_ready,
    input  frl_frame_t       q_frame,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [RMS_W-1:0] m_rms_value,
    output logic [LEN_W-1:0] m_frame_length,
    output logic             m_length_overflow
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_ROOT,
        ST_OUT
    } state_t;

    state_t             state_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [SUM_W-1:0]   x_reg;
    logic [CNT_W-1:0]   div_reg;
    logic [CNT_W-1:0]   rem_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               ovf_reg;
    logic [ROOT_W+1:0]  rrem_reg;
    logic [ROOT_W-1:0]  root_reg;
    logic               m_valid_reg;
    logic [RMS_W-1:0]   rms_reg;
    logic [LEN_W-1:0]   len_reg;
    logic               lovf_reg;

    // one quotient bit per cycle
    logic [CNT_W:0]     d_sh;
    logic               d_ge;
    logic [CNT_W:0]     d_diff;

    // one root bit per cycle
    logic [ROOT_W+3:0]  r_sh;
    logic [ROOT_W+3:0]  r_trial;
    logic               r_ge;
    logic [ROOT_W+3:0]  r_diff;
    logic [RMS_W-1:0]   rms_sat;
    logic               out_free;

    assign d_sh   = {rem_reg, x_reg[SUM_W-1]};
    assign d_ge   = d_sh >= (CNT_W+1)'(div_reg);
    assign d_diff = d_sh - (CNT_W+1)'(div_reg);

    assign r_sh    = {rrem_reg, x_reg[SUM_W-1:SUM_W-2]};
    assign r_trial = (ROOT_W+4)'({root_reg, 2'b01});
    assign r_ge    = r_sh >= r_trial;
    assign r_diff  = r_sh - r_trial;

    assign rms_sat  = (|root_reg[ROOT_W-1:RMS_W]) ? '1 : root_reg[RMS_W-1:0];
    assign out_free = !m_valid_reg || m_ready;

    assign q_ready           = state_reg == ST_IDLE;
    assign m_valid           = m_valid_reg;
    assign m_rms_value       = rms_reg;
    assign m_frame_length    = len_reg;
    assign m_length_overflow = lovf_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            // in ST_OUT the handoff below decides m_valid_reg
            if (m_valid_reg && m_ready && state_reg != ST_OUT) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        // a zero count divides zero by one
                        x_reg     <= (q_frame.count == '0) ? '0 : q_frame.sum;
                        div_reg   <= (q_frame.count == '0) ? CNT_W'(1) : q_frame.count;
                        rem_reg   <= '0;
                        cnt_reg   <= q_frame.count;
                        ovf_reg   <= q_frame.overflow;
                        step_reg  <= STEP_W'(SUM_W - 1);
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    rem_reg <= d_ge ? d_diff[CNT_W-1:0] : d_sh[CNT_W-1:0];
                    x_reg   <= {x_reg[SUM_W-2:0], d_ge};
                    if (step_reg == '0) begin
                        rrem_reg  <= '0;
                        root_reg  <= '0;
                        step_reg  <= STEP_W'(ROOT_W - 1);
                        state_reg <= ST_ROOT;
                    end else begin
                        step_reg <= step_reg - 1'b1;
                    end
                end
                ST_ROOT: begin
                    rrem_reg <= r_ge ? r_diff[ROOT_W+1:0] : r_sh[ROOT_W+1:0];
                    root_reg <= {root_reg[ROOT_W-2:0], r_ge};
                    x_reg    <= {x_reg[SUM_W-3:0], 2'b00};
                    if (step_reg == '0) begin
                        state_reg <= ST_OUT;
                    end else begin
                        step_reg <= step_reg - 1'b1;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        rms_reg     <= rms_sat;
                        len_reg     <= LEN_W'(cnt_reg);
                        lovf_reg    <= ovf_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV |-> div_reg != '0)
        else $error("division by zero in back end");

    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        q_valid && q_ready |=> state_reg == ST_DIV)
        else $error("popped frame not started");

endmodule
